// File: rtl/tkis_pkg.sv
// tkis_pkg: shared types and fixed field widths for the top-k index selector.
// Depends on nothing; imported by tkis_cell and top_k_index_select_core.
`default_nettype none

package tkis_pkg;

   localparam int VAL_W = 32;   // sample width, signed Q16.16
   localparam int POS_W = 12;   // reported position width
   localparam int TC_W  = 5;    // top_count register width

   // One kept list entry: value and its arrival position
   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic [POS_W-1:0]        position;
   } entry_type;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

endpackage

`default_nettype wire

// File: rtl/tkis_cell.sv
// tkis_cell: one compare-and-shift cell of the sorted top-k chain.
// Depends on tkis_pkg (entry_type, VAL_W, POS_W).
`default_nettype none

module tkis_cell
   import tkis_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      ins_en,     // insert new entry this cycle
   input  wire logic      drain_en,   // shift toward the head this cycle
   input  wire logic      valid,      // this cell holds a kept entry
   input  wire entry_type new_entry,
   input  wire logic      up_gt,      // neighbor nearer the head also loses to new entry
   input  wire entry_type up_entry,
   input  wire entry_type dn_entry,
   output logic           gt,
   output entry_type      entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // Strict compare: equal values keep the earlier arrival ahead
   assign gt    = !valid || ($signed(new_entry.value) > $signed(entry_ff.value));
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ins_en) begin
         if (gt && !up_gt) begin
            entry_in = new_entry;
         end else if (gt) begin
            entry_in = up_entry;
         end
      end else if (drain_en) begin
         entry_in = dn_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// File: rtl/top_k_index_select_core.sv
// top_k_index_select_core: streaming top-k position selector, top level.
// Depends on tkis_pkg and tkis_cell.
//
//   channel   ports                                   handshake
//   --------  --------------------------------------  ------------------------------
//   request   req_sample_value, req_is_last           start high, busy low
//   response  rsp_position, rsp_last_of_run           rsp_valid strobe, one cycle
//   csr       csr_write_data (top_count)              csr_write_en, no wait
//
// Samples are taken one per cycle while idle: each enters the chain of cells
// in the cycle it is accepted. The transaction marked last makes the block
// busy until the chain has shifted out n = min(top_count, MAX_TOP, samples
// kept) positions, one per cycle, largest value first. Reset (synchronous,
// active high) empties the list, zeroes the arrival count and sets
// top_count to 1. The receiver cannot stall: each result is shown for
// exactly one cycle.
`default_nettype none

module top_k_index_select_core
   import tkis_pkg::*;
#(
   parameter int MAX_TOP    = 16,
   parameter int MAX_LENGTH = 4096
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic signed [VAL_W-1:0] req_sample_value,
   input  wire logic                    req_is_last,
   output logic                         rsp_valid,
   output logic [POS_W-1:0]             rsp_position,
   output logic                         rsp_last_of_run,
   input  wire logic                    csr_write_en,
   input  wire logic [TC_W-1:0]         csr_write_data
);

   localparam int CW    = $clog2(MAX_TOP + 1);       // kept count width
   localparam int MW    = (CW > TC_W) ? CW : TC_W;   // width for count compares
   localparam int CNT_W = $clog2(MAX_LENGTH);        // arrival counter width

   state_type        state_ff, state_in;
   logic [TC_W-1:0]  top_count_ff;
   logic [CW-1:0]    kept_ff, kept_in;
   logic [CW-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0] arrival_ff, arrival_in;

   logic             accept;
   logic             drain_en;
   logic [CW-1:0]    kept_next;
   logic [MW-1:0]    want;
   logic [MW-1:0]    kept_ext;
   logic [CW-1:0]    run_results;
   logic [POS_W-1:0] arrival_pos;
   entry_type        new_entry;

   logic             gt_w    [MAX_TOP];
   entry_type        entry_w [MAX_TOP];

   assign accept = start && !busy;

   // Map the wrapped arrival count onto the position field
   generate
      if (CNT_W >= POS_W) begin : g_pos_trunc
         assign arrival_pos = arrival_ff[POS_W-1:0];
      end else begin : g_pos_ext
         assign arrival_pos = {{(POS_W - CNT_W){1'b0}}, arrival_ff};
      end
   endgenerate

   assign new_entry.value    = req_sample_value;
   assign new_entry.position = arrival_pos;

   // List grows until full; a full list keeps its size on every insert
   assign kept_next = (kept_ff < CW'(MAX_TOP)) ? kept_ff + CW'(1) : kept_ff;

   // Results for this run: top_count saturated to MAX_TOP, capped by kept size
   assign want        = (MW'(top_count_ff) > MW'(MAX_TOP)) ? MW'(MAX_TOP)
                                                           : MW'(top_count_ff);
   assign kept_ext    = MW'(kept_next);
   assign run_results = (want < kept_ext) ? CW'(want) : kept_next;

   // Chain of cells, head (largest) at index 0
   generate
      for (genvar i = 0; i < MAX_TOP; i++) begin : g_cell
         logic      up_gt;
         entry_type up_entry;
         entry_type dn_entry;

         if (i == 0) begin : g_head
            assign up_gt    = 1'b0;
            assign up_entry = new_entry;
         end else begin : g_body
            assign up_gt    = gt_w[i-1];
            assign up_entry = entry_w[i-1];
         end

         if (i == MAX_TOP - 1) begin : g_tail
            assign dn_entry = entry_w[i];
         end else begin : g_mid
            assign dn_entry = entry_w[i+1];
         end

         tkis_cell u_cell (
            .clock     (clock),
            .ins_en    (accept),
            .drain_en  (drain_en),
            .valid     (kept_ff > CW'(i)),
            .new_entry (new_entry),
            .up_gt     (up_gt),
            .up_entry  (up_entry),
            .dn_entry  (dn_entry),
            .gt        (gt_w[i]),
            .entry     (entry_w[i])
         );
      end
   endgenerate

   // Register write: top_count
   always_ff @(posedge clock) begin
      if (reset) begin
         top_count_ff <= TC_W'(1);
      end else if (csr_write_en) begin
         top_count_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         kept_ff    <= '0;
         rem_ff     <= '0;
         arrival_ff <= '0;
      end else begin
         state_ff   <= state_in;
         kept_ff    <= kept_in;
         rem_ff     <= rem_in;
         arrival_ff <= arrival_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      kept_in    = kept_ff;
      rem_in     = rem_ff;
      arrival_in = arrival_ff;
      busy       = 1'b0;
      drain_en   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kept_in = kept_next;
               if (req_is_last) begin
                  // Latch the result count and restart numbering for the next run
                  rem_in     = run_results;
                  arrival_in = '0;
                  state_in   = ST_DRAIN;
               end else if (arrival_ff == CNT_W'(MAX_LENGTH - 1)) begin
                  arrival_in = '0;
               end else begin
                  arrival_in = arrival_ff + CNT_W'(1);
               end
            end
         end
         ST_DRAIN: begin
            busy     = 1'b1;
            drain_en = (rem_ff != '0);
            if (drain_en) begin
               rem_in = rem_ff - CW'(1);
            end
            // Drop the list once the final position leaves
            if (rem_ff <= CW'(1)) begin
               kept_in  = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Head of the chain is the next position out
   assign rsp_valid       = drain_en;
   assign rsp_position    = entry_w[0].position;
   assign rsp_last_of_run = (rem_ff == CW'(1));

   // Results only appear while a run is draining
   a_rsp_in_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside drain");

   // The flagged result ends the run
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_run) |=> !busy)
      else $error("block still busy after final result");

   // A run-ending transaction always enters the drain phase
   a_last_starts_drain: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_is_last) |=> busy)
      else $error("last sample did not start drain");

   // Kept size never exceeds the chain length
   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      kept_ff <= CW'(MAX_TOP))
      else $error("kept count beyond chain length");

endmodule

`default_nettype wire
